/* sv/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the streaming top-K selector
// Field widths, the default keep count and the controller/datapath signals.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int KEEP_COUNT_DEF = 16;
  localparam int SCORE_W        = 32;
  localparam int NODE_W         = 32;
  localparam int RANK_W         = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;  // consider the accepted pair for the held list
    logic pop;     // move the best held entry into the output register
  } tks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic one_left;  // exactly one entry is still held
  } tks_status_t;

endpackage

/* sv/tks_ctrl.sv */
// ----------------------------------------------------------------------------
// tks_ctrl: controller of the streaming top-K selector
// Collects pairs until the last one, then pops the held entries in order.
// ----------------------------------------------------------------------------
module tks_ctrl
  import tks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_stall,
  input  logic        out_stall,
  output logic        out_valid,
  input  tks_status_t status,
  output tks_cmd_t    cmd
);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_EMIT   = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic load;

  assign load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.insert    = 1'b0;
    cmd.pop       = 1'b0;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_ACCEPT: begin
        in_stall   = 1'b0;
        cmd.insert = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          cmd.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.one_left) begin
            state_nxt = ST_ACCEPT;
          end
        end
      end
      default: state_nxt = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/tks_dpath.sv */
// ----------------------------------------------------------------------------
// tks_dpath: datapath of the streaming top-K selector
// A sorted row of entry cells with insertion, pop-out shifting and the
// registered result stage.
// ----------------------------------------------------------------------------
module tks_dpath
  import tks_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  tks_cmd_t           cmd,
  output tks_status_t        status,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [NODE_W-1:0]  in_node_index,
  output logic [RANK_W-1:0]  out_rank,
  output logic [NODE_W-1:0]  out_node_index_out,
  output logic [SCORE_W-1:0] out_score_out,
  output logic               out_last_result
);

  localparam int CNT_W = $clog2(KEEP_COUNT + 1);

  logic [SCORE_W-1:0] score_r [KEEP_COUNT];
  logic [NODE_W-1:0]  node_r  [KEEP_COUNT];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic [KEEP_COUNT-1:0] ge;  // held entry scores at least the new score
  logic full;

  logic [RANK_W-1:0]  rank_r;
  logic [NODE_W-1:0]  out_node_r;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_last_r;

  assign full            = (count_r == CNT_W'(KEEP_COUNT));
  assign status.one_left = (count_r == CNT_W'(1));

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (score_r[i] >= in_score);
    end
  end

  // Each cell keeps its entry, takes the new pair, takes its upper neighbor's
  // entry when the new pair lands above it, or on a pop its lower neighbor's
  // entry. The list stays sorted, so ge is a run of ones from the top.
  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    logic ge_above;
    logic [SCORE_W-1:0] score_below;
    logic [NODE_W-1:0]  node_below;
    if (i == 0) begin : g_top
      assign ge_above = 1'b1;
    end else begin : g_mid
      assign ge_above = ge[i-1];
    end
    if (i == KEEP_COUNT - 1) begin : g_bot
      assign score_below = score_r[i];
      assign node_below  = node_r[i];
    end else begin : g_up
      assign score_below = score_r[i+1];
      assign node_below  = node_r[i+1];
    end
    if (i == 0) begin : g_top_ff
      always_ff @(posedge clk) begin
        if (cmd.pop) begin
          score_r[i] <= score_below;
          node_r[i]  <= node_below;
        end else if (cmd.insert && !ge[i] && ge_above) begin
          score_r[i] <= in_score;
          node_r[i]  <= in_node_index;
        end
      end
    end else begin : g_mid_ff
      always_ff @(posedge clk) begin
        if (cmd.pop) begin
          score_r[i] <= score_below;
          node_r[i]  <= node_below;
        end else if (cmd.insert && !ge[i]) begin
          if (ge_above) begin
            score_r[i] <= in_score;
            node_r[i]  <= in_node_index;
          end else begin
            score_r[i] <= score_r[i-1];
            node_r[i]  <= node_r[i-1];
          end
        end
      end
    end
  end

  always_comb begin
    count_nxt    = count_r;
    emit_cnt_nxt = emit_cnt_r;
    if (cmd.insert && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.pop) begin
      count_nxt    = count_r - CNT_W'(1);
      emit_cnt_nxt = status.one_left ? '0 : emit_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      emit_cnt_r <= '0;
    end else begin
      count_r    <= count_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rank_r      <= RANK_W'(emit_cnt_r) + RANK_W'(1);
      out_node_r  <= node_r[0];
      out_score_r <= score_r[0];
      out_last_r  <= status.one_left;
    end
  end

  assign out_rank           = rank_r;
  assign out_node_index_out = out_node_r;
  assign out_score_out      = out_score_r;
  assign out_last_result    = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(KEEP_COUNT))
    else $error("held count above keep count");
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.pop))
    else $error("insert and pop in the same cycle");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from an empty list");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && status.one_left) |=> (count_r == '0 && emit_cnt_r == '0))
    else $error("list not cleared after the final pop");
`endif

endmodule

/* sv/streaming_top_k_select_top.sv */
// ----------------------------------------------------------------------------
// streaming_top_k_select_top: streaming top-K selector
// Keeps the KEEP_COUNT largest scores of a pair stream and ranks them out.
// ----------------------------------------------------------------------------
// While collecting, the block takes one (score, node index) item every cycle
// and keeps the KEEP_COUNT highest scores in a sorted row of registers; an
// item inserts into that row in the cycle it is accepted. Once the list is
// full, a new item only enters when its score is strictly above the held
// minimum, and the latest arrival among equal minima is the one dropped.
// When the item marked last has been accepted, the input stalls and the held
// entries come out one per cycle while the output side does not stall, best
// score first with rank counting from 1, ties in arrival order, the final one
// flagged by out_last_result. The input stays stalled until the last held
// entry has been popped, after which the list is empty and collection starts
// again. The emit rate is set by the single output register fed from the
// head of the row. Scores are unsigned Q0.32 fractions compared as plain
// unsigned integers.
// ----------------------------------------------------------------------------
module streaming_top_k_select_top
  import tks_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [NODE_W-1:0]  in_node_index,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RANK_W-1:0]  out_rank,
  output logic [NODE_W-1:0]  out_node_index_out,
  output logic [SCORE_W-1:0] out_score_out,
  output logic               out_last_result
);

  tks_cmd_t    cmd;
  tks_status_t status;

  // The controller sequences collecting and emitting; it owns the handshake.
  tks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the sorted entries and the registered result.
  tks_dpath #(
    .KEEP_COUNT (KEEP_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_score           (in_score),
    .in_node_index      (in_node_index),
    .out_rank           (out_rank),
    .out_node_index_out (out_node_index_out),
    .out_score_out      (out_score_out),
    .out_last_result    (out_last_result)
  );

endmodule

/* test/streaming_top_k_select_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_top_k_select_top_tb: self-checking bench for the top-K selector
// Drives runs of (score, node index) items, predicts the ranked list that each
// item marked last must release, and checks every result field by field.
// ----------------------------------------------------------------------------
module streaming_top_k_select_top_tb;
  import tks_pkg::*;

  localparam int KEEP        = KEEP_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int DIR_N       = 23;

  // One ranked result as the block presents it.
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [NODE_W-1:0]  node;
    logic [SCORE_W-1:0] score;
    logic               last;
  } ranked_t;

  // One stimulus item. Rows with typed set carry their own expected result;
  // they are always single-item runs on an empty list.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [NODE_W-1:0]  node;
    logic               last;
    logic               typed;
    ranked_t            want;
  } item_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [SCORE_W-1:0] in_score      = '0;
  logic [NODE_W-1:0]  in_node_index = '0;
  logic               in_last       = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [RANK_W-1:0]  out_rank;
  logic [NODE_W-1:0]  out_node_index_out;
  logic [SCORE_W-1:0] out_score_out;
  logic               out_last_result;

  streaming_top_k_select_top #(
    .KEEP_COUNT(KEEP)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_score          (in_score),
    .in_node_index     (in_node_index),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rank          (out_rank),
    .out_node_index_out(out_node_index_out),
    .out_score_out     (out_score_out),
    .out_last_result   (out_last_result)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the held list: sorted by descending score, equal scores
  // kept in arrival order, exactly as the block must hold them.
  logic [SCORE_W-1:0] held_score [KEEP];
  logic [NODE_W-1:0]  held_node  [KEEP];
  int                 held_n = 0;

  // Ranked results still owed by the block, oldest first.
  ranked_t ranked_due [$];

  int fault_count = 0;
  int cycle_count = 0;

  // Sender idle and receiver stall chances, in percent.
  int idle_pct  = 0;
  int stall_pct = 0;

  // The main process bumps hold_ticket to ask for one long receiver hold-off;
  // the receiver process notices the change and counts the hold down itself.
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left   = 0;

  ranked_t   seen_want;
  item_row_t dir_rows [DIR_N];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d, %s: got %h, expected %h",
             cycle_count, what, got, want);
    fault_count++;
  endtask

  // Consider one accepted item for the held list and, on the item marked last,
  // queue the full ranked list if queue_ranks is set and empty the shadow copy.
  function automatic void topk_absorb(input logic [SCORE_W-1:0] s,
                                      input logic [NODE_W-1:0] n,
                                      input logic is_last, input bit queue_ranks);
    int      pos;
    int      i;
    ranked_t r;
    // A full list only takes a score strictly above its minimum. The tail
    // entry is the minimum and, among equal minima, the latest arrival.
    if (held_n < KEEP || held_score[KEEP-1] < s) begin
      if (held_n == KEEP)
        held_n--;
      pos = 0;
      while (pos < held_n && held_score[pos] >= s)
        pos++;
      for (i = held_n; i > pos; i--) begin
        held_score[i] = held_score[i-1];
        held_node[i]  = held_node[i-1];
      end
      held_score[pos] = s;
      held_node[pos]  = n;
      held_n++;
    end
    if (is_last) begin
      for (i = 0; i < held_n; i++) begin
        r.rank  = RANK_W'(i + 1);
        r.node  = held_node[i];
        r.score = held_score[i];
        r.last  = (i == held_n - 1);
        if (queue_ranks)
          ranked_due = {ranked_due, r};
      end
      held_n = 0;
    end
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the block takes it. Valid is only lowered when an idle cycle follows.
  task automatic send_item(input item_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_score      <= row.score;
    in_node_index <= row.node;
    in_last       <= row.last;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    topk_absorb(row.score, row.node, row.last, !row.typed);
    if (row.typed)
      ranked_due = {ranked_due, row.want};
  endtask

  // Scores lean towards the extremes; tie runs draw from a few coarse values
  // so that equal scores and equal minima turn up often.
  function automatic logic [SCORE_W-1:0] pick_score(input bit tie_mode);
    logic [SCORE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = '0;
      1: s = '1;
      default: s = tie_mode ? (SCORE_W'($urandom_range(0, 5)) << 29) : $urandom;
    endcase
    return s;
  endfunction

  // Whole runs closed by a last item, mostly short, some well past the keep
  // count so that eviction is exercised. The final run is cut to the quota.
  task automatic send_random_runs(input int quota);
    int        sent;
    int        run_len;
    int        i;
    bit        tie_mode;
    item_row_t row;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 7)
        run_len = $urandom_range(1, 12);
      else
        run_len = $urandom_range(KEEP - 2, 2 * KEEP + 8);
      if (run_len > quota - sent)
        run_len = quota - sent;
      tie_mode = 1'($urandom_range(0, 1));
      for (i = 0; i < run_len; i++) begin
        row       = '0;
        row.score = pick_score(tie_mode);
        row.node  = $urandom;
        row.last  = (i == run_len - 1);
        send_item(row);
        sent++;
      end
    end
  endtask

  task automatic set_phase(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct <= stall;
  endtask

  // Receiver: random stalls, or a long hold-off when one has been asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ranked_due.size() == 0) begin
        report_mismatch("result with none pending", out_node_index_out, '0);
      end else begin
        seen_want = ranked_due.pop_front();
        if (out_rank !== seen_want.rank)
          report_mismatch("rank", 32'(out_rank), 32'(seen_want.rank));
        if (out_node_index_out !== seen_want.node)
          report_mismatch("node index", out_node_index_out, seen_want.node);
        if (out_score_out !== seen_want.score)
          report_mismatch("score", out_score_out, seen_want.score);
        if (out_last_result !== seen_want.last)
          report_mismatch("last result", 32'(out_last_result), 32'(seen_want.last));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Directed items. The first three are single-item runs on an empty list,
    // so each must come straight back as rank 1 and the final result.
    dir_rows = '{
      '{32'h8000_0000, 32'h0000_0005, 1'b1, 1'b1,
        '{7'd1, 32'h0000_0005, 32'h8000_0000, 1'b1}},
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
        '{7'd1, 32'h0000_0000, 32'h0000_0000, 1'b1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
      // Both score extremes in one run of two.
      '{32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, 1'b0, '0},
      // A run that fills the list with a tied pair of minima (100) and a tied
      // pair at 300 that must come out in arrival order.
      '{32'd100,  32'h0000_0010, 1'b0, 1'b0, '0},
      '{32'd300,  32'h0000_0011, 1'b0, 1'b0, '0},
      '{32'd100,  32'h0000_0012, 1'b0, 1'b0, '0},
      '{32'd200,  32'h0000_0013, 1'b0, 1'b0, '0},
      '{32'd300,  32'h0000_0014, 1'b0, 1'b0, '0},
      '{32'd5000, 32'h0000_0020, 1'b0, 1'b0, '0},
      '{32'd5100, 32'h0000_0021, 1'b0, 1'b0, '0},
      '{32'd5200, 32'h0000_0022, 1'b0, 1'b0, '0},
      '{32'd5300, 32'h0000_0023, 1'b0, 1'b0, '0},
      '{32'd5400, 32'h0000_0024, 1'b0, 1'b0, '0},
      '{32'd5500, 32'h0000_0025, 1'b0, 1'b0, '0},
      '{32'd5600, 32'h0000_0026, 1'b0, 1'b0, '0},
      '{32'd5700, 32'h0000_0027, 1'b0, 1'b0, '0},
      '{32'd5800, 32'h0000_0028, 1'b0, 1'b0, '0},
      '{32'd5900, 32'h0000_0029, 1'b0, 1'b0, '0},
      '{32'd6000, 32'h0000_002A, 1'b0, 1'b0, '0},
      // Full now: a score equal to the minimum is dropped, then a larger one
      // evicts the later of the two tied minima and closes the run.
      '{32'd100,  32'h0000_0030, 1'b0, 1'b0, '0},
      '{32'd150,  32'h0000_0031, 1'b1, 1'b0, '0}
    };

    // Synchronous reset, held from time zero and never asserted again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with both sides running freely.
    set_phase(0, 0);
    for (int r = 0; r < DIR_N; r++)
      send_item(dir_rows[r]);

    // Random runs under each idling pattern in turn.
    send_random_runs(20);
    set_phase(68, 0);
    send_random_runs(20);
    set_phase(0, 68);
    send_random_runs(20);
    set_phase(38, 38);
    send_random_runs(20);

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering items, so the block ends up stalling its input
    // while it sits on a ranked list it cannot release.
    set_phase(0, 0);
    hold_ticket <= hold_ticket + 1;
    send_random_runs(KEEP + 4);
    send_random_runs(8);
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then give the block time to show
    // any result it should not produce.
    while (ranked_due.size() != 0)
      @(posedge clk);
    repeat (2 * KEEP + 8) @(posedge clk);

    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
